@@ hw/rtl/stri_pkg.sv @@
// Shared types and constants for the self-terminating random interleaver.
// Used by the front queue, the back engine and the top level; no dependencies.
package stri_pkg;

  localparam int MaxLen     = 1024;
  localparam int AddrW      = $clog2(MaxLen);
  localparam int DrawW      = 10;
  localparam int PosW       = 10;
  localparam int LenW       = 11;
  localparam int OrderW     = 4;
  localparam int PeriodW    = 15;
  localparam int EpochW     = 8;
  localparam int QueueDepth = 2;
  localparam int QPtrW      = 1;
  localparam int QCountW    = 2;
  localparam int CfgIndexW  = 2;
  localparam int CfgDataW   = 11;
  localparam int InDataW    = 16;
  localparam int OutDataW   = 24;

  localparam logic [CfgIndexW-1:0] RegFrameLength = 2'd0;
  localparam logic [CfgIndexW-1:0] RegMemoryOrder = 2'd1;

  localparam logic [EpochW-1:0] EpochFirst = 8'd1;
  localparam logic [EpochW-1:0] EpochLast  = 8'hFF;
  localparam logic [EpochW-1:0] EpochNone  = 8'd0;

  typedef enum logic {
    KindDraw    = 1'b0,
    KindRestart = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [DrawW-1:0]       draw;
  } cmd_t;

  typedef struct packed {
    logic [LenW-1:0]        tau;
    logic [PeriodW-1:0]     period;
  } cfg_t;

  typedef struct packed {
    logic [QCountW-1:0]     count;
  } front_status_t;

  typedef struct packed {
    logic                   sweeping;
    logic                   out_load;
  } eng_status_t;

endpackage

@@ hw/rtl/stri_ram.sv @@
// Generic single-port RAM with registered read data, read-before-write.
// No dependencies.
module stri_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    rdata <= mem[addr];
    if (we) begin
      mem[addr] <= wdata;
    end
  end

endmodule

@@ hw/rtl/stri_front.sv @@
// Front part: accepts input transactions, classifies them and queues them.
// Depends on stri_pkg.
module stri_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [stri_pkg::InDataW-1:0]    s_tdata,   // [9:0] draw, rest zero
  input  logic                            s_tuser,   // [0] restart
  input  logic                            hold,
  output stri_pkg::cmd_t                  cmd,
  output logic                            cmd_valid,
  input  logic                            cmd_pop,
  output stri_pkg::front_status_t         status
);

  stri_pkg::cmd_t                  q [stri_pkg::QueueDepth];
  logic [stri_pkg::QPtrW-1:0]      wr_ptr;
  logic [stri_pkg::QPtrW-1:0]      rd_ptr;
  logic [stri_pkg::QCountW-1:0]    count;
  logic                            push;
  logic                            pop;
  stri_pkg::cmd_t                  incoming;

  assign s_tready = (count != stri_pkg::QCountW'(stri_pkg::QueueDepth)) && !hold;
  assign push     = s_tvalid && s_tready;
  assign pop      = cmd_pop && cmd_valid;
  assign cmd_valid = (count != '0);
  assign cmd       = q[rd_ptr];
  assign status.count = count;

  // classify: a restart flag makes the item clear the frame first
  always_comb begin
    incoming.draw = s_tdata[stri_pkg::DrawW-1:0];
    incoming.kind = s_tuser ? stri_pkg::KindRestart : stri_pkg::KindDraw;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= incoming;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hw/rtl/stri_engine.sv @@
// Back part: divides the draw by the period, checks and marks the used map,
// emits results through an output register. Depends on stri_pkg, stri_ram.
module stri_engine (
  input  logic                                clk,
  input  logic                                rst,
  input  stri_pkg::cfg_t                      cfg,
  input  stri_pkg::cmd_t                      cmd,
  input  logic                                cmd_valid,
  output logic                                cmd_pop,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [stri_pkg::OutDataW-1:0]       m_tdata,
  output logic                                m_tlast,
  output stri_pkg::eng_status_t               status
);

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StSweep  = 6'b000010,
    StDiv    = 6'b000100,
    StLookup = 6'b001000,
    StCheck  = 6'b010000,
    StEmit   = 6'b100000
  } state_t;

  state_t                              state;
  logic [stri_pkg::DrawW-1:0]          draw;
  logic [stri_pkg::DrawW-1:0]          dshift;
  logic [3:0]                          div_cnt;
  logic [stri_pkg::PeriodW-1:0]        rem;
  logic [stri_pkg::PosW-1:0]           fill;
  logic [stri_pkg::PosW-1:0]           res;
  logic [stri_pkg::AddrW-1:0]          cand_reg;
  logic [stri_pkg::AddrW-1:0]          sweep_cnt;
  logic [stri_pkg::EpochW-1:0]         epoch;
  logic                                resume;
  logic [stri_pkg::PosW-1:0]           out_pos;
  logic [stri_pkg::PosW-1:0]           out_idx;
  logic                                out_last;
  logic                                out_valid_q;

  logic [stri_pkg::PeriodW:0]          rem_sh;
  logic [stri_pkg::PeriodW-1:0]        rem_next;
  logic [stri_pkg::LenW-1:0]           cand;
  logic                                clr;
  logic                                is_last;
  logic                                res_wrap;
  logic                                slot_free;
  logic                                out_load;
  logic                                ram_we;
  logic [stri_pkg::AddrW-1:0]          ram_addr;
  logic [stri_pkg::EpochW-1:0]         ram_wdata;
  logic [stri_pkg::EpochW-1:0]         ram_rdata;

  // one restoring step per cycle; only the remainder is kept
  assign rem_sh   = {rem, dshift[stri_pkg::DrawW-1]};
  assign rem_next = (rem_sh >= {1'b0, cfg.period}) ?
                    stri_pkg::PeriodW'(rem_sh - {1'b0, cfg.period}) :
                    rem_sh[stri_pkg::PeriodW-1:0];

  // floor(d/p)*p is d minus its remainder
  assign cand = {1'b0, draw - rem[stri_pkg::DrawW-1:0]} + {1'b0, res};

  assign clr      = (cmd.kind == stri_pkg::KindRestart) || ({1'b0, fill} >= cfg.tau);
  assign is_last  = ({1'b0, fill} + stri_pkg::LenW'(1)) == cfg.tau;
  assign res_wrap = (stri_pkg::PeriodW'(res) + stri_pkg::PeriodW'(1)) >= cfg.period;
  assign slot_free = !m_tvalid || m_tready;
  assign out_load  = (state == StEmit) && slot_free;
  assign cmd_pop   = (state == StIdle) && cmd_valid;

  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = epoch;
    ram_addr  = cand[stri_pkg::AddrW-1:0];
    case (state)
      StSweep: begin
        ram_we    = 1'b1;
        ram_addr  = sweep_cnt;
        ram_wdata = stri_pkg::EpochNone;
      end
      StCheck: begin
        ram_addr = cand_reg;
        ram_we   = (ram_rdata != epoch);
      end
      default: begin
        ram_addr = cand[stri_pkg::AddrW-1:0];
      end
    endcase
  end

  stri_ram #(
    .WIDTH(stri_pkg::EpochW),
    .DEPTH(stri_pkg::MaxLen)
  ) u_used (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign m_tvalid = (out_valid_q);
  assign m_tdata  = {4'b0, out_idx, out_pos};
  assign m_tlast  = out_last;
  assign status.sweeping = (state == StSweep);
  assign status.out_load = out_load;

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pos  <= fill;
      out_idx  <= cand_reg;
      out_last <= is_last;
    end
    if (rst) begin
      state       <= StSweep;
      sweep_cnt   <= '0;
      resume      <= 1'b0;
      epoch       <= stri_pkg::EpochFirst;
      fill        <= '0;
      res         <= '0;
      out_valid_q <= 1'b0;
      div_cnt     <= '0;
      rem         <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state)
        StIdle: begin
          if (cmd_valid) begin
            draw    <= cmd.draw;
            dshift  <= cmd.draw;
            div_cnt <= '0;
            rem     <= '0;
            state   <= StDiv;
            if (clr) begin
              fill <= '0;
              res  <= '0;
              if (epoch == stri_pkg::EpochLast) begin
                state     <= StSweep;
                sweep_cnt <= '0;
                resume    <= 1'b1;
              end else begin
                epoch <= epoch + 1'b1;
              end
            end
          end
        end
        StSweep: begin
          sweep_cnt <= sweep_cnt + 1'b1;
          if (sweep_cnt == stri_pkg::AddrW'(stri_pkg::MaxLen - 1)) begin
            epoch  <= stri_pkg::EpochFirst;
            resume <= 1'b0;
            state  <= resume ? StDiv : StIdle;
          end
        end
        StDiv: begin
          rem     <= rem_next;
          dshift  <= dshift << 1;
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == 4'(stri_pkg::DrawW - 1)) begin
            state <= StLookup;
          end
        end
        StLookup: begin
          cand_reg <= cand[stri_pkg::AddrW-1:0];
          state    <= (cand >= cfg.tau) ? StIdle : StCheck;
        end
        StCheck: begin
          state <= (ram_rdata == epoch) ? StIdle : StEmit;
        end
        StEmit: begin
          if (slot_free) begin
            state <= StIdle;
            if (is_last) begin
              fill <= '0;
              res  <= '0;
              if (epoch == stri_pkg::EpochLast) begin
                state     <= StSweep;
                sweep_cnt <= '0;
                resume    <= 1'b0;
              end else begin
                epoch <= epoch + 1'b1;
              end
            end else begin
              fill <= fill + 1'b1;
              res  <= res_wrap ? '0 : res + 1'b1;
            end
          end
        end
        default: begin
          state <= StIdle;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/self_terminating_random_interleaver.sv @@
// Top level of the self-terminating random interleaver table builder.
// Depends on stri_pkg, stri_front, stri_engine (which holds stri_ram).
//
// Builds a turbo-code permutation table one position at a time from external
// random draws. With period p = 2^memory_order - 1, a draw d proposes the slot
// floor(d/p)*p + (t mod p); a free slot is marked used and the pair (t, slot)
// leaves on the master stream, tlast marking the final position of the frame.
// An occupied or out-of-range slot drops the draw without a result. Input
// transactions enter a two-entry queue, so the source is released while the
// engine works. Each item passes through a dispatch step, the bit-serial
// remainder unit (one draw bit per cycle), a lookup, a used-map check and an
// emit; an out-of-range slot ends the item after the lookup and an occupied
// one after the check. The used map is a 1024 x 8 RAM tagged with a frame
// epoch, so clearing it at restart or end of frame is a single epoch step; on
// reset, and once every 255 clears when the epoch wraps, a clearing pass runs
// through all 1024 RAM entries, during which s_tready
// stays low. Write frame_length (index 0) and memory_order (index 1) only
// while no transaction is in flight.
module self_terminating_random_interleaver (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [stri_pkg::InDataW-1:0]      s_tdata,   // [9:0] draw, [15:10] zero
  input  logic                              s_tuser,   // [0] restart
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [stri_pkg::OutDataW-1:0]     m_tdata,   // [9:0] position, [19:10] mapped_index, [23:20] zero
  output logic                              m_tlast,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [stri_pkg::CfgIndexW-1:0]    cfg_index,
  input  logic [stri_pkg::CfgDataW-1:0]     cfg_data
);

  logic [stri_pkg::LenW-1:0]     frame_length;
  logic [stri_pkg::OrderW-1:0]   memory_order;
  logic [stri_pkg::OrderW-1:0]   order_eff;
  stri_pkg::cfg_t                cfg;
  stri_pkg::cmd_t                cmd;
  logic                          cmd_valid;
  logic                          cmd_pop;
  stri_pkg::front_status_t       front_status;
  stri_pkg::eng_status_t         eng_status;

  // register writes are always taken at once
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length <= stri_pkg::LenW'(stri_pkg::MaxLen);
      memory_order <= stri_pkg::OrderW'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        stri_pkg::RegFrameLength: frame_length <= cfg_data;
        stri_pkg::RegMemoryOrder: memory_order <= cfg_data[stri_pkg::OrderW-1:0];
        default: ;
      endcase
    end
  end

  // order zero acts as one; length zero acts as one, lengths above the
  // table size saturate
  always_comb begin
    order_eff = (memory_order == '0) ? stri_pkg::OrderW'(1) : memory_order;
    cfg.period = stri_pkg::PeriodW'((16'd1 << order_eff) - 16'd1);
    if (frame_length == '0) begin
      cfg.tau = stri_pkg::LenW'(1);
    end else if (frame_length > stri_pkg::LenW'(stri_pkg::MaxLen)) begin
      cfg.tau = stri_pkg::LenW'(stri_pkg::MaxLen);
    end else begin
      cfg.tau = frame_length;
    end
  end

  stri_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .hold     (eng_status.sweeping),
    .cmd      (cmd),
    .cmd_valid(cmd_valid),
    .cmd_pop  (cmd_pop),
    .status   (front_status)
  );

  stri_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .cmd_valid(cmd_valid),
    .cmd_pop  (cmd_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .status   (eng_status)
  );

  // no new transaction is taken while the used map is being cleared
  a_hold_in_sweep: assert property (@(posedge clk) disable iff (rst)
    eng_status.sweeping |-> !s_tready)
    else $error("input accepted during clearing pass");

  // a result never overwrites one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    eng_status.out_load |-> (!m_tvalid || m_tready))
    else $error("pending result overwritten");

  // the queue never holds more than its depth
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    front_status.count <= stri_pkg::QCountW'(stri_pkg::QueueDepth))
    else $error("front queue overflow");

endmodule
